// ===== hdl/sfa_pkg.sv =====
// Shared types and constants of the sprite frame animator.
// No dependencies; used by sfa_div and sprite_frame_animator.
package sfa_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;

    localparam int DELAY_W = 16;
    localparam int CNT_W   = 5;
    localparam int PIX_W   = 12;
    localparam int POS_W   = 16;
    localparam int FRAME_W = 8;
    localparam int MS_W    = 16;
    localparam int ACC_W   = 32;
    localparam int ACT_W   = 2;

    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int PROD_W = DELAY_W + COL_W;
    localparam int CYC_W  = DELAY_W + COL_W + ROW_W;

    localparam int DIV_W  = ACC_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_BITS   = FRAME_W + 2 * POS_W + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H      = 3'd7;

    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH  = 2'd2;

    typedef struct packed {
        logic              go;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== hdl/sfa_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sfa_pkg; the dividend comes left-aligned to the step count.
module sfa_div import sfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    output t_div_sts         o_sts,
    output logic [DIV_W-1:0] o_quot,
    output logic [DIV_W-1:0] o_rem
);

    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] rem_diff;
    logic           fits;

    assign rem_sh   = {r_rem[DIV_W-1:0], r_dvd[DIV_W-1]};
    assign fits     = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.go) begin
                r_rem  <= '0;
                r_dvd  <= i_ctl.dividend;
                r_dvs  <= i_ctl.divisor;
                r_cnt  <= i_ctl.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? rem_diff : rem_sh;
                r_dvd <= {r_dvd[DIV_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_dvd;
    assign o_rem      = r_rem[DIV_W-1:0];

endmodule

// ===== hdl/sprite_frame_animator.sv =====
// Top level of the sprite frame animator: config registers, sequencer, output stage.
// Depends on sfa_pkg and the serial divider sfa_div.
//
// Each transaction on the input stream is one command (tick, restart, force finished)
// and yields exactly one result with the frame index, its sheet corner and the
// finished and wrapped flags. The block works on one item at a time; s_axis_tready
// is high only between items. A restart, a force finished, an unused code or a tick
// while finished goes straight to the column and row split; a tick that ends a
// non-looping animation first compares the sum with the cycle length, a tick that
// does not wrap also divides by the frame delay, and a tick that wraps first takes
// the modulo by the cycle length. Each item uses the one shared bit-serial divider,
// which gives one quotient bit per cycle: 32 steps for the modulo by the cycle length,
// 32 for the division by the frame delay, and 8 for splitting the frame into column
// and row. A result that has not left the output register holds the next result back.
// A finished result waits in the output register while the next item is taken.
// Config writes are taken at any time but belong between items.
module sprite_frame_animator import sfa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [MS_W-1:0]       s_axis_tdata,  // [15:0] elapsed_ms
    input  logic [ACT_W-1:0]      s_axis_tuser,  // [1:0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] frame_index, [23:8] source_x, [39:24] source_y,
    // [40] is_finished, [41] wrapped_this_step, [47:42] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CYC   = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_MOD   = 4'd3;
    localparam logic [3:0] S_FRM   = 4'd4;
    localparam logic [3:0] S_COLGO = 4'd5;
    localparam logic [3:0] S_COL   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;

    logic [DELAY_W-1:0] r_delay;
    logic [CNT_W-1:0]   r_cols;
    logic [CNT_W-1:0]   r_rows;
    logic               r_loop;
    logic [PIX_W-1:0]   r_org_x;
    logic [PIX_W-1:0]   r_org_y;
    logic [PIX_W-1:0]   r_cell_w;
    logic [PIX_W-1:0]   r_cell_h;

    logic [3:0]            r_state, n_state;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [ACC_W-1:0]      r_sum, n_sum;
    logic [FRAME_W-1:0]    r_frame, n_frame;
    logic                  r_fin, n_fin;
    logic                  r_wr, n_wr;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [CYC_W-1:0]      r_cycle, n_cycle;
    logic [COL_W-1:0]      r_col, n_col;
    logic [FRAME_W-1:0]    r_row, n_row;
    logic [POS_W-1:0]      r_px, n_px;
    logic [POS_W-1:0]      r_py, n_py;
    t_div_ctl              r_div, n_div;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic [DELAY_W-1:0]       delay_eff;
    logic [COL_W-1:0]         cols_eff;
    logic [ROW_W-1:0]         rows_eff;
    logic [PROD_W-1:0]        prod_full;
    logic [CYC_W-1:0]         cyc_full;
    logic [PIX_W+COL_W-1:0]   px_full;
    logic [PIX_W+FRAME_W-1:0] py_full;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic                     in_take;
    logic                     out_free;
    t_div_sts                 div_sts;
    logic [DIV_W-1:0]         div_quot;
    logic [DIV_W-1:0]         div_rem;

    sfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_div),
        .o_sts   (div_sts),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign delay_eff = (r_delay == '0) ? DELAY_W'(1) : r_delay;
    assign cols_eff  = (r_cols == '0) ? COL_W'(1) :
                       (32'(r_cols) > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS) : COL_W'(r_cols);
    assign rows_eff  = (r_rows == '0) ? ROW_W'(1) :
                       (32'(r_rows) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(r_rows);

    assign prod_full = delay_eff * cols_eff;
    assign cyc_full  = r_prod * rows_eff;
    assign px_full   = r_cell_w * r_col;
    assign py_full   = r_cell_h * r_row;
    assign pos_x     = POS_W'(r_org_x) + r_px;
    assign pos_y     = POS_W'(r_org_y) + r_py;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_W'(100);
            r_cols   <= CNT_W'(1);
            r_rows   <= CNT_W'(1);
            r_loop   <= 1'b1;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_cell_w <= PIX_W'(32);
            r_cell_h <= PIX_W'(32);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DELAY_MS:    r_delay  <= i_cfg_data[DELAY_W-1:0];
                REG_COLUMNS:     r_cols   <= i_cfg_data[CNT_W-1:0];
                REG_ROWS:        r_rows   <= i_cfg_data[CNT_W-1:0];
                REG_LOOP:        r_loop   <= i_cfg_data[0];
                REG_ORIGIN_X:    r_org_x  <= i_cfg_data[PIX_W-1:0];
                REG_ORIGIN_Y:    r_org_y  <= i_cfg_data[PIX_W-1:0];
                REG_CELL_W:      r_cell_w <= i_cfg_data[PIX_W-1:0];
                REG_CELL_H:      r_cell_h <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_frame     = r_frame;
        n_fin       = r_fin;
        n_wr        = r_wr;
        n_prod      = r_prod;
        n_cycle     = r_cycle;
        n_col       = r_col;
        n_row       = r_row;
        n_px        = r_px;
        n_py        = r_py;
        n_div       = r_div;
        n_div.go    = 1'b0;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_sum  = r_acc + ACC_W'(s_axis_tdata);
                    n_prod = prod_full;
                    n_state = S_COLGO;
                    case (s_axis_tuser)
                        ACT_TICK: begin
                            if (!r_fin) begin
                                n_state = S_CYC;
                            end
                        end
                        ACT_RESTART: begin
                            n_acc   = '0;
                            n_frame = '0;
                            n_fin   = 1'b0;
                            n_wr    = 1'b0;
                        end
                        ACT_FINISH: n_fin = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CYC: begin
                n_cycle = cyc_full;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_div.steps = STEP_W'(DIV_W);
                if (r_sum >= ACC_W'(r_cycle)) begin
                    if (r_loop) begin
                        n_wr           = 1'b1;
                        n_div.go       = 1'b1;
                        n_div.dividend = r_sum;
                        n_div.divisor  = DIV_W'(r_cycle);
                        n_state        = S_MOD;
                    end else begin
                        n_fin   = 1'b1;
                        n_acc   = r_sum;
                        n_state = S_COLGO;
                    end
                end else begin
                    n_wr           = 1'b0;
                    n_acc          = r_sum;
                    n_div.go       = 1'b1;
                    n_div.dividend = r_sum;
                    n_div.divisor  = DIV_W'(delay_eff);
                    n_state        = S_FRM;
                end
            end
            S_MOD: begin
                if (div_sts.done) begin
                    n_acc          = div_rem;
                    n_div.go       = 1'b1;
                    n_div.steps    = STEP_W'(DIV_W);
                    n_div.dividend = div_rem;
                    n_div.divisor  = DIV_W'(delay_eff);
                    n_state        = S_FRM;
                end
            end
            S_FRM: begin
                if (div_sts.done) begin
                    n_frame = div_quot[FRAME_W-1:0];
                    n_state = S_COLGO;
                end
            end
            S_COLGO: begin
                n_div.go       = 1'b1;
                n_div.steps    = STEP_W'(FRAME_W);
                n_div.dividend = {r_frame, {(DIV_W-FRAME_W){1'b0}}};
                n_div.divisor  = DIV_W'(cols_eff);
                n_state        = S_COL;
            end
            S_COL: begin
                if (div_sts.done) begin
                    n_col   = div_rem[COL_W-1:0];
                    n_row   = div_quot[FRAME_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_px    = px_full[POS_W-1:0];
                n_py    = py_full[POS_W-1:0];
                n_state = S_ADD;
            end
            S_ADD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_DATA_W'({r_wr, r_fin, pos_y, pos_x, r_frame});
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_frame     <= '0;
            r_fin       <= 1'b0;
            r_wr        <= 1'b0;
            r_div       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_frame     <= n_frame;
            r_fin       <= n_fin;
            r_wr        <= n_wr;
            r_div       <= n_div;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum          <= n_sum;
        r_prod         <= n_prod;
        r_cycle        <= n_cycle;
        r_col          <= n_col;
        r_row          <= n_row;
        r_px           <= n_px;
        r_py           <= n_py;
        r_out_data     <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_hold_when_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && r_fin && s_axis_tuser == ACT_TICK) |=> $stable(r_acc))
        else $error("accumulator moved on a tick while finished");

    a_acc_in_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRM) |-> (r_acc < ACC_W'(r_cycle)))
        else $error("accumulator not reduced below the cycle length");

    a_div_idle_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div.go |-> !div_sts.busy)
        else $error("divider started while busy");

endmodule
